[src/heat_stencil_update_assert.svh]
// Assertion macros for the heat stencil update block.
`ifndef HEAT_STENCIL_UPDATE_ASSERT_SVH
`define HEAT_STENCIL_UPDATE_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define HSU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/hsu_pkg.sv]
// Shared constants and types of the heat stencil update block.
`default_nettype none

package hsu_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 4096;
  localparam int VALUE_BITS_DEF = 32;

  // Q0.16 coefficients
  localparam int COEF_BITS = 16;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_V    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_H    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_ROWS = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COLS = 2'd3;

  // center and left taps of the window row
  localparam int WIN_TAPS = 2;

  // result queue entries, power of two
  localparam int OUT_DEPTH = 16;

  typedef struct packed {
    logic first;
    logic second;
  } hsu_push_t;

endpackage

`default_nettype wire

[src/hsu_in_if.sv]
// Input channel: one grid cell request per handshake.
`default_nettype none

interface hsu_in_if import hsu_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

`default_nettype wire

[src/hsu_out_if.sv]
// Result channel: one updated cell per handshake.
`default_nettype none

interface hsu_out_if import hsu_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF
);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int COL_BITS = $clog2(MAX_COLS);

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] out_value;
  logic [ROW_BITS-1:0]   out_row;
  logic [COL_BITS-1:0]   out_col;
  logic                  run_last;

  modport source (output valid, output out_value, output out_row, output out_col,
                  output run_last, input ready);
  modport sink   (input valid, input out_value, input out_row, input out_col,
                  input run_last, output ready);
endinterface

`default_nettype wire

[src/hsu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hsu_ram import hsu_pkg::*; #(
  parameter int WIDTH = VALUE_BITS_DEF,
  parameter int DEPTH = MAX_COLS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/hsu_tap_cell.sv]
// One tap of the stencil window row: load or shift from the neighbor.
`default_nettype none

module hsu_tap_cell import hsu_pkg::*; #(
  parameter int WIDTH = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic             load,
  input  logic [WIDTH-1:0] load_d,
  input  logic [WIDTH-1:0] shift_d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (en) begin
      q_nxt = load ? load_d : shift_d;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

[src/hsu_out_fifo.sv]
// Result queue: up to two writes and one read per cycle.
`default_nettype none

module hsu_out_fifo import hsu_pkg::*; #(
  parameter int WIDTH = 55,
  parameter int DEPTH = OUT_DEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int LVL_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hsu_push_t        push,
  input  logic [WIDTH-1:0] wdata0,
  input  logic [WIDTH-1:0] wdata1,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rdata,
  output logic [LVL_W-1:0] level
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [PTR_W-1:0] wp_next_slot;
  logic             pop;
  logic [1:0]       push_cnt;

  assign pop          = rd_valid && rd_ready;
  assign push_cnt     = {1'b0, push.first} + {1'b0, push.second};
  assign wp_next_slot = PTR_W'(wp_r + 1'b1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (push.first && (wp_r == PTR_W'(i))) begin
        mem_r[i] <= wdata0;
      end else if (push.second && (wp_next_slot == PTR_W'(i))) begin
        mem_r[i] <= wdata1;
      end
    end
  end

  always_comb begin
    wp_nxt    = PTR_W'(wp_r + PTR_W'(push_cnt));
    rp_nxt    = pop ? PTR_W'(rp_r + 1'b1) : rp_r;
    level_nxt = LVL_W'(level_r + LVL_W'(push_cnt) - LVL_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      level_r <= level_nxt;
    end
  end

  assign rd_valid = (level_r != '0);
  assign rdata    = mem_r[rp_r];
  assign level    = level_r;

endmodule

`default_nettype wire

[src/heat_stencil_update.sv]
// Heat stencil update top level: one explicit five-point heat-equation step.
//
// Grid cells enter in raster order, one per clock while the result queue
// has room. Each accepted cell (r,c) below row 0 yields the updated cell
// (r-1,c); on the last row the arriving border cell follows as a second
// result. Intake is paced by free space in a 16-entry result queue: a cell
// is taken only while two slots are free. Two line stores of MAX_COLS
// entries hold the previous rows; each is read once per cell and the
// current row's store is written, on separate ports. A two-tap window row
// supplies the center and left neighbors. Line stores are not cleared after
// reset; a grid must be streamed complete from its first row. Interior
// Q0.16 sums round half up to whole values, saturated to VALUE_BITS.
`default_nettype none

`include "heat_stencil_update_assert.svh"

module heat_stencil_update import hsu_pkg::*; #(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int ROW_BITS    = $clog2(MAX_ROWS),
  localparam int COL_BITS    = $clog2(MAX_COLS),
  localparam int GRID_ROWS_W = ROW_BITS + 1,
  localparam int GRID_COLS_W = COL_BITS + 1,
  localparam int CFG_W       = (COEF_BITS >= GRID_ROWS_W && COEF_BITS >= GRID_COLS_W)
                               ? COEF_BITS
                               : ((GRID_ROWS_W >= GRID_COLS_W) ? GRID_ROWS_W : GRID_COLS_W)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  hsu_in_if.sink                  in_chan,
  hsu_out_if.source               out_chan,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int VB    = VALUE_BITS;
  localparam int DW    = VB + 2;
  localparam int PW    = DW + COEF_BITS;
  localparam int AW    = PW + 1;
  localparam int SW    = AW - COEF_BITS + 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) << (COEF_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI     = {{(SW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO     = {{(SW-VB+1){1'b1}}, {(VB-1){1'b0}}};

  typedef struct packed {
    logic                above;
    logic                last_row;
    logic                interior;
    logic                swap;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic [VB-1:0]       cur;
  } meta_t;

  typedef struct packed {
    logic [VB-1:0]       value;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } res_t;

  // configuration
  logic [COEF_BITS-1:0]   coef_v_r, coef_h_r;
  logic [GRID_ROWS_W-1:0] grid_rows_r;
  logic [GRID_COLS_W-1:0] grid_cols_r;
  logic [GRID_ROWS_W-1:0] rows_eff;
  logic [GRID_COLS_W-1:0] cols_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_v_r    <= '0;
      coef_h_r    <= '0;
      grid_rows_r <= GRID_ROWS_W'(1);
      grid_cols_r <= GRID_COLS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_V:    coef_v_r    <= cfg_data[COEF_BITS-1:0];
        CFG_COEF_H:    coef_h_r    <= cfg_data[COEF_BITS-1:0];
        CFG_GRID_ROWS: grid_rows_r <= cfg_data[GRID_ROWS_W-1:0];
        CFG_GRID_COLS: grid_cols_r <= cfg_data[GRID_COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (grid_rows_r == '0) begin
      rows_eff = GRID_ROWS_W'(1);
    end else if (grid_rows_r > GRID_ROWS_W'(MAX_ROWS)) begin
      rows_eff = GRID_ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
    priority if (grid_cols_r == '0) begin
      cols_eff = GRID_COLS_W'(1);
    end else if (grid_cols_r > GRID_COLS_W'(MAX_COLS)) begin
      cols_eff = GRID_COLS_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  // intake and position
  logic                   in_acc;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   swap_r, swap_nxt;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [GRID_ROWS_W-1:0] row_p1;
  logic [GRID_COLS_W-1:0] col_p1;
  logic                   last_row, last_col, col_zero, above, interior;
  logic [1:0]             n_res;
  logic                   out_pop;
  logic [CNT_W-1:0]       fifo_level;

  assign in_chan.ready = (cnt_r <= CNT_W'(OUT_DEPTH - 2));
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign row_p1   = GRID_ROWS_W'({1'b0, row_r} + 1'b1);
  assign col_p1   = GRID_COLS_W'({1'b0, col_r} + 1'b1);
  assign last_row = (row_p1 >= rows_eff);
  assign last_col = (col_p1 >= cols_eff);
  assign col_zero = (col_r == '0);
  assign above    = (row_r != '0);
  assign interior = (row_r > ROW_BITS'(1)) && ({1'b0, row_r} < rows_eff)
                    && !col_zero && (col_p1 < cols_eff);
  assign n_res    = {1'b0, above} + {1'b0, last_row};

  always_comb begin
    swap_nxt = swap_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    cnt_nxt  = CNT_W'(cnt_r + (in_acc ? CNT_W'(n_res) : '0) - CNT_W'(out_pop));
    if (in_acc) begin
      if (last_col) begin
        col_nxt  = '0;
        swap_nxt = !swap_r;
        row_nxt  = last_row ? '0 : row_p1[ROW_BITS-1:0];
      end else begin
        col_nxt = col_p1[COL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      swap_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      swap_r <= swap_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // line stores
  logic [VB-1:0]       rd_a, rd_b, newer_rd;
  logic [COL_BITS-1:0] col_ahead;

  assign col_ahead = COL_BITS'(col_r + 1'b1);
  assign newer_rd  = swap_r ? rd_a : rd_b;

  hsu_ram #(.WIDTH(VB), .DEPTH(MAX_COLS)) u_store_a (
    .clk   (clk),
    .we    (in_acc && !swap_r),
    .waddr (col_r),
    .wdata (in_chan.cell_value),
    .re    (in_acc),
    .raddr (swap_r ? col_ahead : col_r),
    .rdata (rd_a)
  );

  hsu_ram #(.WIDTH(VB), .DEPTH(MAX_COLS)) u_store_b (
    .clk   (clk),
    .we    (in_acc && swap_r),
    .waddr (col_r),
    .wdata (in_chan.cell_value),
    .re    (in_acc),
    .raddr (swap_r ? col_r : col_ahead),
    .rdata (rd_b)
  );

  // window row: tap 0 is the center, tap 1 the left neighbor
  logic [VB-1:0] first_r;
  logic [VB-1:0] tap_q [WIN_TAPS];

  always_ff @(posedge clk) begin
    if (in_acc && col_zero) begin
      first_r <= in_chan.cell_value;
    end
  end

  for (genvar i = 0; i < WIN_TAPS; i++) begin : g_tap
    if (i == 0) begin : g_head
      hsu_tap_cell #(.WIDTH(VB)) u_cell (
        .clk     (clk),
        .en      (in_acc),
        .load    (col_zero),
        .load_d  (first_r),
        .shift_d (newer_rd),
        .q       (tap_q[i])
      );
    end else begin : g_body
      hsu_tap_cell #(.WIDTH(VB)) u_cell (
        .clk     (clk),
        .en      (in_acc),
        .load    (1'b0),
        .load_d  (tap_q[i-1]),
        .shift_d (tap_q[i-1]),
        .q       (tap_q[i])
      );
    end
  end

  // stage 1: neighbor differences
  logic              s1_v_r;
  meta_t             s1_m_r;
  logic [VB-1:0]     s1_up, s1_right, s1_ctr, s1_left;
  logic signed [DW-1:0] s1_dv, s1_dh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_m_r <= '{above: above, last_row: last_row, interior: interior, swap: swap_r,
                  row: row_r, col: col_r, cur: in_chan.cell_value};
    end
  end

  assign s1_up    = s1_m_r.swap ? rd_b : rd_a;
  assign s1_right = s1_m_r.swap ? rd_a : rd_b;
  assign s1_ctr   = tap_q[0];
  assign s1_left  = tap_q[WIN_TAPS-1];

  assign s1_dv = {{2{s1_up[VB-1]}}, s1_up} + {{2{s1_m_r.cur[VB-1]}}, s1_m_r.cur}
                 - {s1_ctr[VB-1], s1_ctr, 1'b0};
  assign s1_dh = {{2{s1_left[VB-1]}}, s1_left} + {{2{s1_right[VB-1]}}, s1_right}
                 - {s1_ctr[VB-1], s1_ctr, 1'b0};

  // stage 2: weight the differences
  logic                         s2_v_r;
  meta_t                        s2_m_r;
  logic [VB-1:0]                s2_ctr_r;
  logic signed [DW-1:0]         s2_dv_r, s2_dh_r;
  logic signed [DW+COEF_BITS:0] prod_v, prod_h;

  always_ff @(posedge clk) begin
    s2_m_r   <= s1_m_r;
    s2_ctr_r <= s1_ctr;
    s2_dv_r  <= s1_dv;
    s2_dh_r  <= s1_dh;
  end

  assign prod_v = s2_dv_r * $signed({1'b0, coef_v_r});
  assign prod_h = s2_dh_r * $signed({1'b0, coef_h_r});

  // stage 3: sum with rounding
  logic                 s3_v_r;
  meta_t                s3_m_r;
  logic [VB-1:0]        s3_ctr_r;
  logic signed [PW-1:0] s3_pv_r, s3_ph_r;
  logic signed [AW-1:0] s3_acc;

  always_ff @(posedge clk) begin
    s3_m_r   <= s2_m_r;
    s3_ctr_r <= s2_ctr_r;
    s3_pv_r  <= prod_v[PW-1:0];
    s3_ph_r  <= prod_h[PW-1:0];
  end

  assign s3_acc = {s3_pv_r[PW-1], s3_pv_r} + {s3_ph_r[PW-1], s3_ph_r} + ROUND_HALF;

  // stage 4: add to center, saturate, queue results
  logic                 s4_v_r;
  meta_t                s4_m_r;
  logic [VB-1:0]        s4_ctr_r;
  logic signed [AW-1:0] s4_acc_r;
  logic signed [SW-1:0] s4_sum;
  logic [VB-1:0]        s4_sat, s4_value;
  res_t                 res_above, res_border, res_out;
  hsu_push_t            push;

  always_ff @(posedge clk) begin
    s4_m_r   <= s3_m_r;
    s4_ctr_r <= s3_ctr_r;
    s4_acc_r <= s3_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  assign s4_sum = {{(SW-VB){s4_ctr_r[VB-1]}}, s4_ctr_r}
                  + {s4_acc_r[AW-1], s4_acc_r[AW-1:COEF_BITS]};

  always_comb begin
    priority if (s4_sum > SAT_HI) begin
      s4_sat = SAT_HI[VB-1:0];
    end else if (s4_sum < SAT_LO) begin
      s4_sat = SAT_LO[VB-1:0];
    end else begin
      s4_sat = s4_sum[VB-1:0];
    end
  end

  assign s4_value   = s4_m_r.interior ? s4_sat : s4_ctr_r;
  assign res_above  = '{value: s4_value, row: ROW_BITS'(s4_m_r.row - 1'b1),
                        col: s4_m_r.col, last: !s4_m_r.last_row};
  assign res_border = '{value: s4_m_r.cur, row: s4_m_r.row, col: s4_m_r.col, last: 1'b1};

  assign push.first  = s4_v_r && (s4_m_r.above || s4_m_r.last_row);
  assign push.second = s4_v_r && s4_m_r.above && s4_m_r.last_row;

  hsu_out_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wdata0   (s4_m_r.above ? res_above : res_border),
    .wdata1   (res_border),
    .rd_valid (out_chan.valid),
    .rd_ready (out_chan.ready),
    .rdata    (res_out),
    .level    (fifo_level)
  );

  assign out_pop            = out_chan.valid && out_chan.ready;
  assign out_chan.out_value = res_out.value;
  assign out_chan.out_row   = res_out.row;
  assign out_chan.out_col   = res_out.col;
  assign out_chan.run_last  = res_out.last;

  `HSU_ASSERT_ALWAYS(a_credit_bound, clk, rst_n, cnt_r <= CNT_W'(OUT_DEPTH), "result credits overrun")
  `HSU_ASSERT_ALWAYS(a_queue_covered, clk, rst_n, fifo_level <= cnt_r, "queue exceeds reserved slots")
  `HSU_ASSERT_NEXT(a_col_advance, clk, rst_n, in_acc && !last_col, col_r == COL_BITS'($past(col_r) + 1'b1), "column did not advance")
  `HSU_ASSERT_NEXT(a_grid_wrap, clk, rst_n, in_acc && last_col && last_row, row_r == '0 && col_r == '0, "grid end did not wrap")

endmodule

`default_nettype wire
